@@ rtl/core/chs_pkg.sv @@
// shared types and constants of the chained hash set
package chs_pkg;

	// multiplier constant (sqrt(7)-1)/2 in Q0.32, truncated
	localparam logic [31:0] A_Q32 = 32'd3534224029;

	// widths of the request and result fields
	localparam int KEY_W    = 31;
	localparam int BUCKET_W = 3;

	// request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_en;
		logic cap;
		logic mul1;
		logic mul2;
		logic fill_rd;
		logic ins_wr;
		logic scan_init;
		logic scan_run;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last;
		logic fill_full;
		logic hit;
		logic scan_done;
	} stat_t;

endpackage

@@ rtl/core/chs_ctrl.sv @@
// controller state machine of the chained hash set
module chs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           mode,
	input  chs_pkg::stat_t st,
	output chs_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done,
	output logic           found,
	output logic           status
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_FRD,
		S_FCHK,
		S_SCAN
	} state_t;

	state_t state_q;
	logic   mode_q;
	logic   done_q;
	logic   found_q;
	logic   status_q;

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			mode_q   <= chs_pkg::MODE_INSERT;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (st.clr_last)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FRD;
				S_FRD:  state_q <= S_FCHK;
				S_FCHK: begin
					if (mode_q == chs_pkg::MODE_INSERT) begin
						done_q   <= 1'b1;
						status_q <= st.fill_full;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (st.hit) begin
						done_q  <= 1'b1;
						found_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (st.scan_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// datapath commands decoded from state
	always_comb begin
		cmd           = '0;
		cmd.clr_en    = (state_q == S_CLEAR);
		cmd.cap       = (state_q == S_IDLE) && start;
		cmd.mul1      = (state_q == S_MUL1);
		cmd.mul2      = (state_q == S_MUL2);
		cmd.fill_rd   = (state_q == S_FRD);
		cmd.ins_wr    = (state_q == S_FCHK) && (mode_q == chs_pkg::MODE_INSERT)
		                && !st.fill_full;
		cmd.scan_init = (state_q == S_FCHK);
		cmd.scan_run  = (state_q == S_SCAN);
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign found  = found_q;
	assign status = status_q;

endmodule

@@ rtl/core/chs_dp.sv @@
// datapath of the chained hash set: hash, fill counts, key store, compare
module chs_dp #(
	parameter int BUCKETS      = 8,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  chs_pkg::cmd_t                cmd,
	input  logic [chs_pkg::KEY_W-1:0]    key,
	output chs_pkg::stat_t               st,
	output logic [chs_pkg::BUCKET_W-1:0] bucket
);

	localparam int BW  = $clog2(BUCKETS);
	localparam int BNW = $clog2(BUCKETS + 1);
	localparam int SW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int FW  = $clog2(BUCKET_DEPTH + 1);
	localparam int AW  = BW + SW;
	localparam int XW  = (BW > chs_pkg::BUCKET_W) ? BW : chs_pkg::BUCKET_W;
	localparam int P1W = chs_pkg::KEY_W + 32;
	localparam int P2W = 32 + BNW;

	logic [chs_pkg::KEY_W-1:0] key_q;
	logic [31:0]               frac_q;
	logic [BW-1:0]             bucket_q;
	logic [FW-1:0]             fill_rd_q;
	logic [chs_pkg::KEY_W-1:0] key_rd_q;
	logic [FW-1:0]             idx_q;
	logic                      cmp_vld_q;
	logic [BW-1:0]             clr_idx_q;

	logic [FW-1:0]             fill_mem [BUCKETS];
	logic [chs_pkg::KEY_W-1:0] key_mem  [2**AW];

	logic [P1W-1:0] prod1;
	logic [P2W-1:0] prod2;
	logic           issue;
	logic           hit;
	logic [XW-1:0]  bucket_ext;

	// multiplication method: fractional product, then scale by bucket count
	assign prod1 = P1W'(key_q) * P1W'(chs_pkg::A_Q32);
	assign prod2 = P2W'(frac_q) * P2W'(BUCKETS);

	// request capture and hash registers
	always_ff @(posedge clk) begin
		if (cmd.cap)
			key_q <= key;
		if (cmd.mul1)
			frac_q <= prod1[31:0];
		if (cmd.mul2)
			bucket_q <= prod2[32 +: BW];
	end

	// clearing pass over the fill counts after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_en) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// fill count memory
	always_ff @(posedge clk) begin
		if (cmd.clr_en)
			fill_mem[clr_idx_q] <= '0;
		else if (cmd.ins_wr)
			fill_mem[bucket_q] <= fill_rd_q + 1'b1;
		if (cmd.fill_rd)
			fill_rd_q <= fill_mem[bucket_q];
	end

	// key store, one read or one write per cycle
	assign issue = cmd.scan_run && (idx_q != fill_rd_q);

	always_ff @(posedge clk) begin
		if (cmd.ins_wr)
			key_mem[{bucket_q, fill_rd_q[SW-1:0]}] <= key_q;
		if (issue)
			key_rd_q <= key_mem[{bucket_q, idx_q[SW-1:0]}];
	end

	// scan counter, compare runs one slot behind the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else if (cmd.scan_init) begin
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else if (cmd.scan_run) begin
			cmp_vld_q <= issue;
			if (issue)
				idx_q <= idx_q + 1'b1;
		end
	end

	assign hit = cmp_vld_q && (key_rd_q == key_q);

	// status back to the controller
	always_comb begin
		st           = '0;
		st.clr_last  = (clr_idx_q == BW'(BUCKETS - 1));
		st.fill_full = (fill_rd_q >= FW'(BUCKET_DEPTH));
		st.hit       = hit;
		st.scan_done = (idx_q == fill_rd_q) && !hit;
	end

	assign bucket_ext = XW'(bucket_q);
	assign bucket     = bucket_ext[chs_pkg::BUCKET_W-1:0];

endmodule

@@ rtl/core/chained_hash_set_insert_search_top.sv @@
// top level of the chained hash set with insert and search
//
// A request is taken at a rising edge with start high and busy low: mode 0
// inserts key into its bucket, mode 1 searches the bucket for key. Each
// request gives exactly one result, shown for one cycle with done high:
// found (search hit), status (1 when an insert met a full bucket) and the
// low bits of the bucket index. The receiver cannot stall; a result must
// be taken in the cycle done is high.
// An insert ends after the hash and the fill count check; a search then
// compares the bucket's slots in order up to and including a hit, or as
// many as its fill count on a miss. The hash takes two multiply stages and
// one fill count read; a search reads the key store one slot per cycle
// through its single port, with the compare in the cycle after each read.
// busy drops in the cycle done is high, so the next request may follow.
// After reset busy stays high while the fill counts are cleared one bucket
// per cycle; stored keys are not cleared.
module chained_hash_set_insert_search_top #(
	parameter int BUCKETS      = 8,
	parameter int BUCKET_DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         mode,
	input  logic [chs_pkg::KEY_W-1:0]    key,
	output logic                         done,
	output logic                         found,
	output logic                         status,
	output logic [chs_pkg::BUCKET_W-1:0] bucket
);

	chs_pkg::cmd_t  cmd;
	chs_pkg::stat_t st;

	// controller
	chs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.found  (found),
		.status (status)
	);

	// datapath
	chs_dp #(
		.BUCKETS      (BUCKETS),
		.BUCKET_DEPTH (BUCKET_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.key    (key),
		.st     (st),
		.bucket (bucket)
	);

endmodule

@@ rtl/core/chs_checker.sv @@
// port checker of the chained hash set and its bind
module chs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic found,
	input logic status
);

	// an accepted request keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// a result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a result only ends a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a request in flight");

	// a search hit and a full-bucket reject never come together
	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && status))
		else $error("found and full status both set");

endmodule

bind chained_hash_set_insert_search_top chs_checker u_chs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.found  (found),
	.status (status)
);
